// ===== sv/psu_pkg.sv =====
package psu_pkg;

  // Word and record field widths.
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CHIP_W   = 8;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned AMP_W    = 12;
  localparam int unsigned USED_W   = 17;
  localparam int unsigned GROUPS_W = 14;
  localparam int unsigned LEFT_W   = 13;

  // A header count above this marks an error report segment.
  localparam logic [WORD_W-1:0] ERROR_LIMIT = 16'd4095;

  // Defaults for the top-level parameters.
  localparam int unsigned VALUE_BITS_DEF  = 12;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Reciprocal of five for a 16-bit dividend: (w * 52429) >> 18 is exact.
  localparam logic [WORD_W-1:0] RECIP5     = 16'd52429;
  localparam int unsigned       RECIP5_SHR = 18;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT     = 2'd0,
    KIND_END     = 2'd1,
    KIND_END_ERR = 2'd2
  } kind_e;

  // Work handed from the parser to the record builder.
  typedef enum logic [2:0] {
    OP_TAG,
    OP_AMP,
    OP_HIT,
    OP_END_NORM,
    OP_END_ERR
  } op_e;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C
  } amp_sel_e;

  typedef struct packed {
    op_e                 op;
    amp_sel_e            sel;
    logic [WORD_W-1:0]   word;
    logic [USED_W-1:0]   used;
  } entry_t;

endpackage

// ===== sv/psu_front.sv =====
module psu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       data_word_i,
  input  logic              first_word_i,
  input  logic              start_odd_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output psu_pkg::entry_t   push_entry_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT_HI,
    PH_ERR_SKIP,
    PH_CHAN_COUNT,
    PH_STAMP,
    PH_GROUP,
    PH_PAD
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [psu_pkg::LEFT_W-1:0]        left_q, left_d;
  logic [2:0]                        gpos_q, gpos_d;
  logic [psu_pkg::GROUPS_W-1:0]      groups_q, groups_d;
  logic                              parity_q, parity_d;
  logic [psu_pkg::WORD_W-1:0]        header_q, header_d;
  logic [psu_pkg::USED_W-1:0]        used_q, used_d;

  logic                              accept;
  logic [psu_pkg::LEFT_W-1:0]        left_dec;
  logic [psu_pkg::GROUPS_W-1:0]      groups_dec;
  logic [psu_pkg::LEFT_W-1:0]        pad_words;
  logic [2*psu_pkg::WORD_W-1:0]      quot_prod;
  logic [psu_pkg::USED_W-1:0]        used_inc;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  assign left_dec   = (left_q != '0) ? left_q - 1'b1 : left_q;
  assign groups_dec = (groups_q != '0) ? groups_q - 1'b1 : groups_q;
  assign used_inc   = used_q + 1'b1;
  // Padding length follows the parity of the word after the current one.
  assign pad_words  = (parity_q ^ 1'b1) ? psu_pkg::LEFT_W'(3) : psu_pkg::LEFT_W'(2);
  assign quot_prod  = data_word_i * psu_pkg::RECIP5;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    gpos_d   = gpos_q;
    groups_d = groups_q;
    parity_d = parity_q;
    header_d = header_q;
    used_d   = used_q;

    push_valid_o       = 1'b0;
    push_entry_o.op    = psu_pkg::OP_TAG;
    push_entry_o.sel   = psu_pkg::SEL_A;
    push_entry_o.word  = data_word_i;
    push_entry_o.used  = used_inc;

    if (accept) begin
      if (first_word_i) begin
        header_d = data_word_i;
        used_d   = psu_pkg::USED_W'(1);
        parity_d = ~start_odd_i;
        left_d   = '0;
        gpos_d   = '0;
        groups_d = '0;
        phase_d  = PH_COUNT_HI;
      end else if (phase_q != PH_IDLE) begin
        used_d   = used_inc;
        parity_d = ~parity_q;
        case (phase_q)
          PH_COUNT_HI: begin
            if (header_q > psu_pkg::ERROR_LIMIT) begin
              left_d  = {header_q[11:0], 1'b1};
              phase_d = PH_ERR_SKIP;
            end else begin
              phase_d = PH_CHAN_COUNT;
            end
          end
          PH_ERR_SKIP: begin
            left_d = left_dec;
            if (left_dec == '0) begin
              push_valid_o      = 1'b1;
              push_entry_o.op   = psu_pkg::OP_END_ERR;
              push_entry_o.word = header_q;
              phase_d           = PH_IDLE;
            end
          end
          PH_CHAN_COUNT: begin
            groups_d = quot_prod[psu_pkg::RECIP5_SHR +: psu_pkg::GROUPS_W];
            left_d   = psu_pkg::LEFT_W'(4);
            phase_d  = PH_STAMP;
          end
          PH_STAMP: begin
            left_d = left_dec;
            if (left_dec == '0) begin
              if (groups_q != '0) begin
                gpos_d  = '0;
                phase_d = PH_GROUP;
              end else begin
                left_d  = pad_words;
                phase_d = PH_PAD;
              end
            end
          end
          PH_GROUP: begin
            push_valid_o = 1'b1;
            case (gpos_q)
              3'd0: begin
                push_entry_o.op = psu_pkg::OP_TAG;
                gpos_d          = 3'd1;
              end
              3'd1: begin
                push_entry_o.op  = psu_pkg::OP_AMP;
                push_entry_o.sel = psu_pkg::SEL_A;
                gpos_d           = 3'd2;
              end
              3'd2: begin
                push_entry_o.op  = psu_pkg::OP_AMP;
                push_entry_o.sel = psu_pkg::SEL_B;
                gpos_d           = 3'd3;
              end
              3'd3: begin
                push_entry_o.op  = psu_pkg::OP_AMP;
                push_entry_o.sel = psu_pkg::SEL_C;
                gpos_d           = 3'd4;
              end
              default: begin
                push_entry_o.op = psu_pkg::OP_HIT;
                gpos_d          = '0;
                groups_d        = groups_dec;
                if (groups_dec == '0) begin
                  left_d  = pad_words;
                  phase_d = PH_PAD;
                end
              end
            endcase
          end
          PH_PAD: begin
            left_d = left_dec;
            if (left_dec == '0) begin
              push_valid_o      = 1'b1;
              push_entry_o.op   = psu_pkg::OP_END_NORM;
              push_entry_o.word = header_q;
              phase_d           = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      left_q   <= '0;
      gpos_q   <= '0;
      groups_q <= '0;
      parity_q <= 1'b0;
      header_q <= '0;
      used_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      gpos_q   <= gpos_d;
      groups_q <= groups_d;
      parity_q <= parity_d;
      header_q <= header_d;
      used_q   <= used_d;
    end
  end

endmodule

// ===== sv/psu_queue.sv =====
module psu_queue #(
  parameter int unsigned DEPTH = psu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  psu_pkg::entry_t   push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output psu_pkg::entry_t   pop_entry_o
);

  // DEPTH must be at least two; the block itself does not enforce this.
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  psu_pkg::entry_t   mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/psu_back.sv =====
module psu_back #(
  parameter int unsigned VALUE_BITS = psu_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  psu_pkg::entry_t               pop_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [psu_pkg::KIND_W-1:0]    kind_o,
  output logic [psu_pkg::CHIP_W-1:0]    chip_id_o,
  output logic [psu_pkg::CHAN_W-1:0]    channel_num_o,
  output logic [psu_pkg::AMP_W-1:0]     amp_a_o,
  output logic [psu_pkg::AMP_W-1:0]     amp_b_o,
  output logic [psu_pkg::AMP_W-1:0]     amp_c_o,
  output logic [psu_pkg::AMP_W-1:0]     hit_time_o,
  output logic [psu_pkg::WORD_W-1:0]    reported_count_o,
  output logic [psu_pkg::USED_W-1:0]    words_used_o
);

  // Only the low bits that survive both the value cut and the field width are kept.
  localparam int unsigned HoldW = (VALUE_BITS < psu_pkg::AMP_W) ? VALUE_BITS : psu_pkg::AMP_W;

  logic [psu_pkg::CHIP_W-1:0]   chip_q;
  logic [psu_pkg::CHAN_W-1:0]   chan_q;
  logic [HoldW-1:0]             amp_a_q, amp_b_q, amp_c_q;
  logic                         out_valid_q;
  logic [psu_pkg::KIND_W-1:0]   kind_q;
  logic [psu_pkg::CHIP_W-1:0]   chip_out_q;
  logic [psu_pkg::CHAN_W-1:0]   chan_out_q;
  logic [psu_pkg::AMP_W-1:0]    amp_a_out_q, amp_b_out_q, amp_c_out_q, time_out_q;
  logic [psu_pkg::WORD_W-1:0]   count_out_q;
  logic [psu_pkg::USED_W-1:0]   used_out_q;

  logic                         emits;
  logic                         slot_free;
  logic                         take;
  logic [HoldW-1:0]             value;

  assign emits = (pop_entry_i.op == psu_pkg::OP_HIT) ||
                 (pop_entry_i.op == psu_pkg::OP_END_NORM) ||
                 (pop_entry_i.op == psu_pkg::OP_END_ERR);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_ready_o = !emits || slot_free;
  assign take        = pop_valid_i && pop_ready_o;
  assign value       = pop_entry_i.word[HoldW-1:0];

  // Partial hit held between the tag word and the last group word.
  always_ff @(posedge clk_i) begin
    if (take) begin
      case (pop_entry_i.op)
        psu_pkg::OP_TAG: begin
          chip_q <= pop_entry_i.word[12:5];
          chan_q <= pop_entry_i.word[2:0];
        end
        psu_pkg::OP_AMP: begin
          case (pop_entry_i.sel)
            psu_pkg::SEL_A: amp_a_q <= value;
            psu_pkg::SEL_B: amp_b_q <= value;
            default:        amp_c_q <= value;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emits) begin
      if (pop_entry_i.op == psu_pkg::OP_HIT) begin
        kind_q      <= psu_pkg::KIND_HIT;
        chip_out_q  <= chip_q;
        chan_out_q  <= chan_q;
        amp_a_out_q <= psu_pkg::AMP_W'(amp_a_q);
        amp_b_out_q <= psu_pkg::AMP_W'(amp_b_q);
        amp_c_out_q <= psu_pkg::AMP_W'(amp_c_q);
        time_out_q  <= psu_pkg::AMP_W'(value);
        count_out_q <= '0;
        used_out_q  <= '0;
      end else begin
        kind_q      <= (pop_entry_i.op == psu_pkg::OP_END_ERR) ?
                       psu_pkg::KIND_END_ERR : psu_pkg::KIND_END;
        chip_out_q  <= '0;
        chan_out_q  <= '0;
        amp_a_out_q <= '0;
        amp_b_out_q <= '0;
        amp_c_out_q <= '0;
        time_out_q  <= '0;
        count_out_q <= pop_entry_i.word;
        used_out_q  <= pop_entry_i.used;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && emits) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign chip_id_o        = chip_out_q;
  assign channel_num_o    = chan_out_q;
  assign amp_a_o          = amp_a_out_q;
  assign amp_b_o          = amp_b_out_q;
  assign amp_c_o          = amp_c_out_q;
  assign hit_time_o       = time_out_q;
  assign reported_count_o = count_out_q;
  assign words_used_o     = used_out_q;

endmodule

// ===== sv/psd_segment_unpacker.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    data_word_i, first_word_i, start_odd_i
// out      output     out_valid_o / out_ready_i  kind_o, chip_id_o, channel_num_o,
//                                                amp_a_o, amp_b_o, amp_c_o, hit_time_o,
//                                                reported_count_o, words_used_o
//
// One word is taken every cycle while the work queue has room; the parser updates
// its phase in the cycle the word is accepted.
// A record leaves through the queue and then the output register once the word
// that completes it has been accepted by the parser.
// Reset is asynchronous and active low and returns the parser to waiting for a first word.
// An output stall fills the queue; in_ready_o drops only once the queue is full.
module psd_segment_unpacker #(
  parameter int unsigned VALUE_BITS  = psu_pkg::VALUE_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = psu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [psu_pkg::WORD_W-1:0]    data_word_i,
  input  logic                          first_word_i,
  input  logic                          start_odd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [psu_pkg::KIND_W-1:0]    kind_o,
  output logic [psu_pkg::CHIP_W-1:0]    chip_id_o,
  output logic [psu_pkg::CHAN_W-1:0]    channel_num_o,
  output logic [psu_pkg::AMP_W-1:0]     amp_a_o,
  output logic [psu_pkg::AMP_W-1:0]     amp_b_o,
  output logic [psu_pkg::AMP_W-1:0]     amp_c_o,
  output logic [psu_pkg::AMP_W-1:0]     hit_time_o,
  output logic [psu_pkg::WORD_W-1:0]    reported_count_o,
  output logic [psu_pkg::USED_W-1:0]    words_used_o
);

  // The parser turns every word that matters for a record (tag, value, last group
  // word, end of segment) into one queue entry. Header, timestamp and the other
  // skipped and padding words only move the parser state and push nothing.
  logic              push_valid, push_ready;
  psu_pkg::entry_t   push_entry;
  logic              pop_valid, pop_ready;
  psu_pkg::entry_t   pop_entry;

  psu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .first_word_i (first_word_i),
    .start_odd_i  (start_odd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // The queue decouples the parser from output stalls.
  psu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // The builder collects the tag and values of a group and loads finished
  // records into the output register; entries that only fill the hold
  // registers drain even while the output is stalled.
  psu_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_entry_i      (pop_entry),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .chip_id_o        (chip_id_o),
    .channel_num_o    (channel_num_o),
    .amp_a_o          (amp_a_o),
    .amp_b_o          (amp_b_o),
    .amp_c_o          (amp_c_o),
    .hit_time_o       (hit_time_o),
    .reported_count_o (reported_count_o),
    .words_used_o     (words_used_o)
  );

endmodule

// ===== tb/sv/segment_record_checker.sv =====
// Watches both channels of the segment unpacker, predicts the records from the
// accepted words and compares every accepted record with the oldest prediction.
module segment_record_checker
  import psu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [WORD_W-1:0] data_word_i,
  input  logic              first_word_i,
  input  logic              start_odd_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [CHIP_W-1:0] chip_id_i,
  input  logic [CHAN_W-1:0] channel_num_i,
  input  logic [AMP_W-1:0]  amp_a_i,
  input  logic [AMP_W-1:0]  amp_b_i,
  input  logic [AMP_W-1:0]  amp_c_i,
  input  logic [AMP_W-1:0]  hit_time_i,
  input  logic [WORD_W-1:0] reported_count_i,
  input  logic [USED_W-1:0] words_used_i,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                hits_o,
  output int                ends_o,
  output int                err_ends_o
);

  localparam int unsigned VAL_MASK = (1 << VALUE_BITS_DEF) - 1;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_COUNT_HI,
    SEG_SKIP,
    SEG_CHANS,
    SEG_STAMP,
    SEG_GROUP,
    SEG_PAD
  } seg_phase_e;

  typedef struct packed {
    kind_e              kind;
    logic [CHIP_W-1:0]  chip;
    logic [CHAN_W-1:0]  chan;
    logic [AMP_W-1:0]   amp_a;
    logic [AMP_W-1:0]   amp_b;
    logic [AMP_W-1:0]   amp_c;
    logic [AMP_W-1:0]   hit_time;
    logic [WORD_W-1:0]  count;
    logic [USED_W-1:0]  used;
  } record_t;

  seg_phase_e          seg_phase;
  logic [15:0]         left_cnt;
  logic [2:0]          grp_pos;
  logic [GROUPS_W-1:0] grp_left;
  logic                next_odd;
  logic [WORD_W-1:0]   hdr_count;
  logic [USED_W-1:0]   used_cnt;
  logic [CHIP_W-1:0]   tag_chip;
  logic [CHAN_W-1:0]   tag_chan;
  logic [AMP_W-1:0]    amp_hold [3];
  record_t             pending_records [$];

  task automatic start_padding();
    left_cnt  = next_odd ? 16'd3 : 16'd2;
    seg_phase = SEG_PAD;
  endtask

  task automatic push_end(input kind_e kind);
    record_t rec;
    rec       = '0;
    rec.kind  = kind;
    rec.count = hdr_count;
    rec.used  = used_cnt;
    pending_records.push_back(rec);
    seg_phase = SEG_IDLE;
  endtask

  // Follows the segment layout one word at a time and queues the record, if any,
  // that the word completes.
  task automatic parse_word(input logic [WORD_W-1:0] w, input logic first,
                            input logic odd);
    logic [AMP_W-1:0] v;
    record_t          rec;
    v   = AMP_W'(32'(w) & VAL_MASK);
    rec = '0;
    if (first) begin
      hdr_count = w;
      used_cnt  = 1;
      next_odd  = ~odd;
      left_cnt  = '0;
      grp_pos   = '0;
      grp_left  = '0;
      seg_phase = SEG_COUNT_HI;
      return;
    end
    if (seg_phase == SEG_IDLE) return;
    used_cnt = used_cnt + 1'b1;
    next_odd = ~next_odd;
    case (seg_phase)
      SEG_COUNT_HI: begin
        if (hdr_count > ERROR_LIMIT) begin
          left_cnt  = 16'((32'(hdr_count) & 32'hfff) * 2 + 1);
          seg_phase = SEG_SKIP;
        end else begin
          seg_phase = SEG_CHANS;
        end
      end
      SEG_SKIP: begin
        if (left_cnt != 0) left_cnt = left_cnt - 1'b1;
        if (left_cnt == 0) push_end(KIND_END_ERR);
      end
      SEG_CHANS: begin
        grp_left  = GROUPS_W'(w / 5);
        left_cnt  = 16'd4;
        seg_phase = SEG_STAMP;
      end
      SEG_STAMP: begin
        if (left_cnt != 0) left_cnt = left_cnt - 1'b1;
        if (left_cnt == 0) begin
          if (grp_left != 0) begin
            grp_pos   = '0;
            seg_phase = SEG_GROUP;
          end else begin
            start_padding();
          end
        end
      end
      SEG_GROUP: begin
        if (grp_pos == 0) begin
          tag_chip = w[12:5];
          tag_chan = w[2:0];
          grp_pos  = 3'd1;
        end else if (grp_pos < 4) begin
          amp_hold[grp_pos-1] = v;
          grp_pos = grp_pos + 1'b1;
        end else begin
          rec.kind     = KIND_HIT;
          rec.chip     = tag_chip;
          rec.chan     = tag_chan;
          rec.amp_a    = amp_hold[0];
          rec.amp_b    = amp_hold[1];
          rec.amp_c    = amp_hold[2];
          rec.hit_time = v;
          pending_records.push_back(rec);
          grp_pos = '0;
          if (grp_left != 0) grp_left = grp_left - 1'b1;
          if (grp_left == 0) start_padding();
        end
      end
      SEG_PAD: begin
        if (left_cnt != 0) left_cnt = left_cnt - 1'b1;
        if (left_cnt == 0) push_end(KIND_END);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt_o++;
    end
  endtask

  task automatic take_record();
    record_t want;
    if (pending_records.size() == 0) begin
      $error("record of kind %0d arrived with none outstanding", kind_i);
      fail_cnt_o++;
      return;
    end
    want = pending_records.pop_front();
    check_field("kind", want.kind, kind_i);
    check_field("chip_id", want.chip, chip_id_i);
    check_field("channel_num", want.chan, channel_num_i);
    check_field("amp_a", want.amp_a, amp_a_i);
    check_field("amp_b", want.amp_b, amp_b_i);
    check_field("amp_c", want.amp_c, amp_c_i);
    check_field("hit_time", want.hit_time, hit_time_i);
    check_field("reported_count", want.count, reported_count_i);
    check_field("words_used", want.used, words_used_i);
    case (kind_i)
      KIND_HIT: hits_o++;
      KIND_END: ends_o++;
      default:  err_ends_o++;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_phase   = SEG_IDLE;
      left_cnt    = '0;
      grp_pos     = '0;
      grp_left    = '0;
      next_odd    = 1'b0;
      hdr_count   = '0;
      used_cnt    = '0;
      tag_chip    = '0;
      tag_chan    = '0;
      amp_hold[0] = '0;
      amp_hold[1] = '0;
      amp_hold[2] = '0;
      fail_cnt_o  = 0;
      hits_o      = 0;
      ends_o      = 0;
      err_ends_o  = 0;
      pending_records.delete();
    end else begin
      if (in_valid_i && in_ready_i) parse_word(data_word_i, first_word_i, start_odd_i);
      if (out_valid_i && out_ready_i) take_record();
    end
    pending_o = pending_records.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the segment unpacker bench. It builds the word stream, drives the input
// channel in bursts, stalls the output channel on its own pattern and gives the
// verdict. All prediction and comparison lives in the checker instance.
module testbench;
  import psu_pkg::*;

  // Upper bound on segment length for a segment that runs to its end.
  localparam int FULL = 1 << 30;
  // Words within segments that the random part aims for.
  localparam int TARGET_WORDS = 1550;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              first;
    logic              odd;
  } beat_t;

  // Output side patterns: free flow, coin toss, mostly stalled, mostly ready.
  typedef enum int {
    RX_FREE,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid_i;
  logic              in_ready_o;
  logic [WORD_W-1:0] data_word_i;
  logic              first_word_i;
  logic              start_odd_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [KIND_W-1:0] kind_o;
  logic [CHIP_W-1:0] chip_id_o;
  logic [CHAN_W-1:0] channel_num_o;
  logic [AMP_W-1:0]  amp_a_o;
  logic [AMP_W-1:0]  amp_b_o;
  logic [AMP_W-1:0]  amp_c_o;
  logic [AMP_W-1:0]  hit_time_o;
  logic [WORD_W-1:0] reported_count_o;
  logic [USED_W-1:0] words_used_o;

  int fail_cnt;
  int pending;
  int hits;
  int ends;
  int err_ends;

  beat_t stim_q [$];
  int    seg_words;

  always #5 clk_i = ~clk_i;

  psd_segment_unpacker u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_word_i      (data_word_i),
    .first_word_i     (first_word_i),
    .start_odd_i      (start_odd_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .chip_id_o        (chip_id_o),
    .channel_num_o    (channel_num_o),
    .amp_a_o          (amp_a_o),
    .amp_b_o          (amp_b_o),
    .amp_c_o          (amp_c_o),
    .hit_time_o       (hit_time_o),
    .reported_count_o (reported_count_o),
    .words_used_o     (words_used_o)
  );

  segment_record_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_word_i      (data_word_i),
    .first_word_i     (first_word_i),
    .start_odd_i      (start_odd_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_i           (kind_o),
    .chip_id_i        (chip_id_o),
    .channel_num_i    (channel_num_o),
    .amp_a_i          (amp_a_o),
    .amp_b_i          (amp_b_o),
    .amp_c_i          (amp_c_o),
    .hit_time_i       (hit_time_o),
    .reported_count_i (reported_count_o),
    .words_used_i     (words_used_o),
    .fail_cnt_o       (fail_cnt),
    .pending_o        (pending),
    .hits_o           (hits),
    .ends_o           (ends),
    .err_ends_o       (err_ends)
  );

  // Queues one word for the driver. Words that the block drops because no
  // segment is open are not counted toward the words within segments.
  task automatic push_word(input logic [WORD_W-1:0] w, input logic first,
                           input logic odd, input bit counted);
    stim_q.push_back('{word: w, first: first, odd: odd});
    if (counted) seg_words++;
  endtask

  // A data segment: two count words, the channel count, four time stamps, the
  // groups of five and the padding. The segment is cut after "cut" words when
  // cut is below its length, which leaves it for the next first word to abandon.
  task automatic add_normal(input logic [WORD_W-1:0] count, input logic [WORD_W-1:0] chans,
                            input logic odd, input int cut);
    logic [WORD_W-1:0] body [$];
    int                n_groups;
    int                pad;
    int                g;
    n_groups = chans / 5;
    // The padding depends on the parity of the offset reached after the groups:
    // the first word sits at an offset of parity "odd", and 7 + 5 * groups words
    // precede the padding.
    pad = (odd ^ ((7 + 5 * n_groups) & 1)) ? 3 : 2;
    body.push_back(16'($urandom));
    body.push_back(chans);
    repeat (4) body.push_back(16'($urandom));
    for (g = 0; g < n_groups && body.size() + 1 < cut; g++) begin
      repeat (5) body.push_back(16'($urandom));
    end
    if (body.size() == 6 + 5 * n_groups) begin
      repeat (pad) body.push_back(16'($urandom));
    end
    push_word(count, 1'b1, odd, 1'b1);
    foreach (body[i]) begin
      if (i + 1 < cut) push_word(body[i], 1'b0, 1'($urandom), 1'b1);
    end
  endtask

  // An error report: two count words and (count & 0xfff) * 2 + 1 skipped words.
  task automatic add_error(input logic [WORD_W-1:0] count, input logic odd, input int cut);
    int skip;
    int i;
    skip = (32'(count) & 32'hfff) * 2 + 1;
    push_word(count, 1'b1, odd, 1'b1);
    for (i = 0; i < skip + 1 && i + 1 < cut; i++) begin
      push_word(16'($urandom), 1'b0, 1'($urandom), 1'b1);
    end
  endtask

  task automatic build_directed();
    // A word with no segment open is dropped without a record.
    push_word(16'hffff, 1'b0, 1'b1, 1'b0);
    // Smallest error report: the count just above the limit skips one word.
    add_error(16'h1000, 1'b0, FULL);
    // Count right at the limit is a normal segment. One group whose tag and
    // values carry all-ones, all-zeros and bits above the value width; the
    // upper count word is all ones and must not matter. Odd start, so the
    // offset after the group is odd and three padding words follow.
    push_word(16'd4095, 1'b1, 1'b1, 1'b1);
    push_word(16'hffff, 1'b0, 1'b0, 1'b1);
    push_word(16'd9, 1'b0, 1'b1, 1'b1);
    push_word(16'h0000, 1'b0, 1'b0, 1'b1);
    push_word(16'hffff, 1'b0, 1'b1, 1'b1);
    push_word(16'h0000, 1'b0, 1'b0, 1'b1);
    push_word(16'hffff, 1'b0, 1'b1, 1'b1);
    push_word(16'hffff, 1'b0, 1'b0, 1'b1);
    push_word(16'h0000, 1'b0, 1'b1, 1'b1);
    push_word(16'hffff, 1'b0, 1'b0, 1'b1);
    push_word(16'h0fff, 1'b0, 1'b1, 1'b1);
    push_word(16'hf000, 1'b0, 1'b0, 1'b1);
    repeat (3) push_word(16'h5a5a, 1'b0, 1'b1, 1'b1);
    // The largest count opens an error report that a new first word abandons.
    push_word(16'hffff, 1'b1, 1'b0, 1'b1);
    push_word(16'h0000, 1'b0, 1'b0, 1'b1);
    // Channel count just below one group goes straight to padding.
    add_normal(16'd0, 16'd4, 1'b0, FULL);
  endtask

  // Mostly complete segments with random content; the rest are cut segments
  // that the next first word abandons and stray words.
  task automatic build_random();
    int                pick;
    logic              odd;
    logic [WORD_W-1:0] count;
    bit                open_seg;
    open_seg = 1'b0;
    while (seg_words < TARGET_WORDS) begin
      pick  = $urandom_range(0, 99);
      odd   = 1'($urandom);
      count = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'd4095 : 16'd0)
                                          : 16'($urandom_range(0, 4095));
      if (pick < 55) begin
        add_normal(count, 16'(5 * $urandom_range(0, 6) + $urandom_range(0, 4)), odd, FULL);
        open_seg = 1'b0;
      end else if (pick < 70) begin
        count = {4'($urandom_range(1, 15)),
                 12'((pick == 69) ? $urandom_range(0, 63) : $urandom_range(0, 20))};
        add_error(count, odd, FULL);
        open_seg = 1'b0;
      end else if (pick < 85) begin
        // Huge channel counts only ever appear in cut segments.
        add_normal(count, ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(5, 40)),
                   odd, $urandom_range(1, 20));
        open_seg = 1'b1;
      end else if (pick < 92) begin
        add_error({4'($urandom_range(1, 15)), 12'($urandom)}, odd, $urandom_range(1, 8));
        open_seg = 1'b1;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          push_word(16'($urandom), 1'b0, 1'($urandom), open_seg);
        end
      end
    end
    // Close with a complete segment so that every record is drained.
    add_normal(16'($urandom_range(0, 4095)), 16'd12, 1'($urandom), FULL);
  endtask

  // Output side. After a short free-flowing start it refuses records for a long
  // stretch while the sender keeps offering words, so the internal queue fills
  // and in_ready_o must drop. Then it cycles through random stall patterns.
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    out_ready_i = 1'b0;
    wait (rst_ni);
    repeat (150) @(negedge clk_i) out_ready_i = 1'b1;
    repeat (400) @(negedge clk_i) out_ready_i = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          RX_FREE:   out_ready_i = 1'b1;
          RX_HALF:   out_ready_i = 1'($urandom);
          RX_SPARSE: out_ready_i = ($urandom_range(0, 3) == 0);
          default:   out_ready_i = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    beat_t item;
    int    burst;
    int    gap;
    int    total_words;
    int    drain;
    int    leftover;

    in_valid_i   = 1'b0;
    data_word_i  = '0;
    first_word_i = 1'b0;
    start_odd_i  = 1'b0;
    seg_words    = 0;
    leftover     = 0;

    build_directed();
    build_random();
    total_words = stim_q.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Words go out in bursts; an occasional long burst runs with no idling at
    // all. Valid is lowered only between bursts, never within one.
    burst = 0;
    while (stim_q.size() > 0) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 24);
        gap   = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      item         = stim_q.pop_front();
      in_valid_i   = 1'b1;
      data_word_i  = item.word;
      first_word_i = item.first;
      start_odd_i  = item.odd;
      do @(posedge clk_i); while (!in_ready_o);
      @(negedge clk_i);
      burst--;
    end
    in_valid_i = 1'b0;

    // Let every predicted record come out, then allow a few more cycles so
    // that a stray extra record would still be caught by the checker.
    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (10) @(negedge clk_i);
    if (pending != 0) begin
      $error("%0d predicted records never arrived", pending);
      leftover = pending;
    end

    $display("Sent %0d words (%0d inside segments) including cut and abandoned segments.",
             total_words, seg_words);
    $display("Checked %0d hit records, %0d segment ends and %0d error report ends.",
             hits, ends, err_ends);
    if (fail_cnt + leftover == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
